@@ hw/rtl/tma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg
// Types, constants and helpers shared by the trimmed mean averager.
// ----------------------------------------------------------------------------
package tma_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SUM_BITS        = 24;
    localparam int COUNT_BITS      = 8;
    localparam int KEEP_EXT        = 5;
    localparam int KEEP_IDX_BITS   = $clog2(KEEP_EXT);
    localparam int MAX_SAMPLES_DEF = 128;
    localparam int QUEUE_DEPTH     = 2;
    localparam int REM_BITS        = SUM_BITS + 2;
    localparam int STEP_BITS       = $clog2(REM_BITS);

    localparam logic [COUNT_BITS-1:0] N_FIVE  = COUNT_BITS'(19);
    localparam logic [COUNT_BITS-1:0] N_THREE = COUNT_BITS'(10);
    localparam logic [COUNT_BITS-1:0] N_TWO   = COUNT_BITS'(6);
    localparam logic [COUNT_BITS-1:0] N_ONE   = COUNT_BITS'(2);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic                          overflow;
    } t_out;

    // one closed run, handed from front to back
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [COUNT_BITS-1:0]      n;
        t_sample [KEEP_EXT-1:0]     lowest;
        t_sample [KEEP_EXT-1:0]     highest;
        logic                       overflow;
    } t_run;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRIM,
        S_DIV,
        S_DONE
    } t_back_state;

    function automatic logic [KEEP_IDX_BITS-1:0] trim_count(input logic [COUNT_BITS-1:0] n);
        logic [KEEP_IDX_BITS-1:0] k;
        priority if (n > N_FIVE) begin
            k = KEEP_IDX_BITS'(5);
        end else if (n > N_THREE) begin
            k = KEEP_IDX_BITS'(3);
        end else if (n > N_TWO) begin
            k = KEEP_IDX_BITS'(2);
        end else if (n > N_ONE) begin
            k = KEEP_IDX_BITS'(1);
        end else begin
            k = '0;
        end
        return k;
    endfunction

endpackage

@@ hw/rtl/tma_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_front
// Accumulates a run: sum, count and the five lowest and highest samples.
// ----------------------------------------------------------------------------
module tma_front #(
    parameter int MAX_SAMPLES = tma_pkg::MAX_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  tma_pkg::t_in  i_data,
    input  logic          i_q_full,
    output logic          o_q_push,
    output tma_pkg::t_run o_q_data
);

    localparam int SB = tma_pkg::SAMPLE_BITS;
    localparam int KE = tma_pkg::KEEP_EXT;

    logic signed [tma_pkg::SUM_BITS-1:0]   r_sum, n_sum;
    logic [tma_pkg::COUNT_BITS-1:0]        r_count, n_count;
    tma_pkg::t_sample [KE-1:0]             r_small, n_small, r_large, n_large;
    logic                                  r_ovf, n_ovf;

    logic          acc;
    logic          take;
    logic [KE-1:0] lt, gt;
    tma_pkg::t_run rec;

    assign acc  = push && !i_q_full;
    assign full = i_q_full;
    assign take = r_count < tma_pkg::COUNT_BITS'(MAX_SAMPLES);

    always_comb begin
        for (int i = 0; i < KE; i++) begin
            lt[i] = i_data.sample < $signed(r_small[i]);
            gt[i] = i_data.sample > $signed(r_large[i]);
        end
        // lists are sorted, so lt and gt are thermometer codes
        for (int j = 0; j < KE; j++) begin
            if (!lt[j]) begin
                n_small[j] = r_small[j];
            end else if (j == 0 || !lt[(j == 0) ? 0 : j-1]) begin
                n_small[j] = i_data.sample;
            end else begin
                n_small[j] = r_small[(j == 0) ? 0 : j-1];
            end
            if (!gt[j]) begin
                n_large[j] = r_large[j];
            end else if (j == 0 || !gt[(j == 0) ? 0 : j-1]) begin
                n_large[j] = i_data.sample;
            end else begin
                n_large[j] = r_large[(j == 0) ? 0 : j-1];
            end
        end
        if (take) begin
            n_sum   = r_sum + {{(tma_pkg::SUM_BITS-SB){i_data.sample[SB-1]}}, i_data.sample};
            n_count = r_count + 1'b1;
            n_ovf   = r_ovf;
        end else begin
            n_sum   = r_sum;
            n_count = r_count;
            n_small = r_small;
            n_large = r_large;
            n_ovf   = 1'b1;
        end
        rec.sum      = n_sum;
        rec.n        = n_count;
        rec.lowest   = n_small;
        rec.highest  = n_large;
        rec.overflow = n_ovf;
    end

    assign o_q_push = acc && i_data.last;
    assign o_q_data = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_data.last)) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_small <= {KE{tma_pkg::SAMPLE_TOP}};
            r_large <= {KE{tma_pkg::SAMPLE_BOT}};
        end else if (acc) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_small <= n_small;
            r_large <= n_large;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tma_pkg::COUNT_BITS'(MAX_SAMPLES))
        else $error("run count beyond cap");

endmodule

@@ hw/rtl/tma_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_queue
// Short queue of closed runs between front and back.
// ----------------------------------------------------------------------------
module tma_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tma_pkg::t_run i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tma_pkg::t_run o_data
);

    localparam int D  = tma_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;

    tma_pkg::t_run     r_mem [D];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;
    logic              wr, rd;

    assign o_full  = r_cnt == (PW+1)'(D);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(D-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(D-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(D))
        else $error("queue count beyond depth");

endmodule

@@ hw/rtl/tma_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_back
// Trims the extremes of a closed run and divides by the kept count.
// ----------------------------------------------------------------------------
module tma_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tma_pkg::t_run i_q_data,
    output logic          o_q_pop,
    output logic          empty,
    input  logic          pop,
    output tma_pkg::t_out o_data
);

    localparam int RB = tma_pkg::REM_BITS;
    localparam int SB = tma_pkg::SAMPLE_BITS;
    localparam int CB = tma_pkg::COUNT_BITS;
    localparam int KB = tma_pkg::KEEP_IDX_BITS;
    localparam int TB = tma_pkg::STEP_BITS;

    tma_pkg::t_back_state r_state, n_state;
    tma_pkg::t_run        r_rec, n_rec;
    logic [KB-1:0]        r_k, n_k, r_i, n_i;
    logic signed [RB-1:0] r_rem, n_rem;
    logic                 r_neg, n_neg;
    logic [RB-1:0]        r_dvd, n_dvd;
    logic [CB-1:0]        r_rmd, n_rmd, r_d, n_d;
    logic [TB-1:0]        r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    tma_pkg::t_out        r_out, n_out;

    logic signed [RB-1:0] pair;
    logic [CB:0]          shifted;
    logic                 fits;

    always_comb begin
        pair = {{(RB-SB){r_rec.lowest[r_i][SB-1]}}, r_rec.lowest[r_i]}
             + {{(RB-SB){r_rec.highest[r_i][SB-1]}}, r_rec.highest[r_i]};
        shifted = {r_rmd, r_dvd[RB-1]};
        fits    = shifted >= {1'b0, r_d};

        n_state     = r_state;
        n_rec       = r_rec;
        n_k         = r_k;
        n_i         = r_i;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_dvd       = r_dvd;
        n_rmd       = r_rmd;
        n_d         = r_d;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        o_q_pop     = 1'b0;

        unique case (r_state)
            tma_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_rec   = i_q_data;
                    n_k     = tma_pkg::trim_count(i_q_data.n);
                    n_i     = '0;
                    n_rem   = {{(RB-tma_pkg::SUM_BITS){i_q_data.sum[tma_pkg::SUM_BITS-1]}},
                               i_q_data.sum};
                    n_state = tma_pkg::S_TRIM;
                end
            end
            tma_pkg::S_TRIM: begin
                if (r_i == r_k) begin
                    n_neg   = r_rem[RB-1];
                    n_dvd   = r_rem[RB-1] ? RB'(-r_rem) : RB'(r_rem);
                    n_rmd   = '0;
                    n_d     = r_rec.n - {r_k, 1'b0};
                    n_step  = '0;
                    n_state = (r_rec.n == '0) ? tma_pkg::S_DONE : tma_pkg::S_DIV;
                end else begin
                    n_rem = r_rem - pair;
                    n_i   = r_i + 1'b1;
                end
            end
            tma_pkg::S_DIV: begin
                n_rmd  = fits ? CB'(shifted - {1'b0, r_d}) : shifted[CB-1:0];
                n_dvd  = {r_dvd[RB-2:0], fits};
                n_step = r_step + 1'b1;
                if (r_step == TB'(RB-1)) begin
                    n_state = tma_pkg::S_DONE;
                end
            end
            tma_pkg::S_DONE: begin
                if (!r_out_valid || pop) begin
                    n_out.mean     = r_neg ? -r_dvd[SB-1:0] : r_dvd[SB-1:0];
                    n_out.overflow = r_rec.overflow;
                    n_out_valid    = 1'b1;
                    n_state        = tma_pkg::S_IDLE;
                end
            end
            default: n_state = tma_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tma_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec  <= n_rec;
        r_k    <= n_k;
        r_i    <= n_i;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_dvd  <= n_dvd;
        r_rmd  <= n_rmd;
        r_d    <= n_d;
        r_step <= n_step;
        r_out  <= n_out;
    end

    assign empty  = !r_out_valid;
    assign o_data = r_out;

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tma_pkg::S_DONE && r_out_valid && !pop) |=> r_state == tma_pkg::S_DONE)
        else $error("result overwritten before transfer");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tma_pkg::S_DIV |-> r_step <= TB'(RB-1))
        else $error("divider ran past last bit");

    a_trim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tma_pkg::S_TRIM |-> (r_i <= r_k && r_k <= KB'(tma_pkg::KEEP_EXT)))
        else $error("trim index out of range");

endmodule

@@ hw/rtl/trimmed_mean_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_averager
// Trimmed mean of a run of signed samples closed by a last flag.
//
//   channel  direction  transfer when          payload
//   input    in         push && !full          i_data  (sample, last)
//   result   out        pop && !empty          o_data  (mean, overflow)
//
// One sample per cycle on the input side while the run queue has room.
// Each closed run is trimmed in the back end (k pairs of extremes, k up to 5),
// then divided bit-serially by the kept count, and the result is loaded.
// Two closed runs can wait between front and back; full rises when both wait.
// Reset is synchronous, active low, and clears the run, queue and output valid.
// ----------------------------------------------------------------------------
module trimmed_mean_averager #(
    parameter int MAX_SAMPLES = tma_pkg::MAX_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  tma_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output tma_pkg::t_out o_data
);

    logic          q_push, q_full, q_valid, q_pop;
    tma_pkg::t_run q_in, q_out;

    tma_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .i_q_full(q_full),
        .o_q_push(q_push),
        .o_q_data(q_in)
    );

    tma_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    tma_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_out),
        .o_q_pop  (q_pop),
        .empty    (empty),
        .pop      (pop),
        .o_data   (o_data)
    );

endmodule

@@ bench/trimmed_mean_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_checker
// Watches both queue ports of the trimmed mean averager. Every input transfer
// updates an independent copy of the run state; the sample that closes a run
// queues the expected mean and overflow flag. Every result transfer is checked
// field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module trimmed_mean_checker #(
    parameter int MAX_SAMPLES = tma_pkg::MAX_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  tma_pkg::t_in  i_in_data,
    input  logic          i_empty,
    input  logic          i_pop,
    input  tma_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    logic signed [tma_pkg::SUM_BITS-1:0] run_sum;
    logic [tma_pkg::COUNT_BITS-1:0]      run_count;
    tma_pkg::t_sample                    lo_five [tma_pkg::KEEP_EXT];
    tma_pkg::t_sample                    hi_five [tma_pkg::KEEP_EXT];
    logic                                run_ovf;
    tma_pkg::t_out                       mean_queue [$];
    int                                  fail_count = 0;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_run();
        run_sum   = '0;
        run_count = '0;
        run_ovf   = 1'b0;
        for (int i = 0; i < tma_pkg::KEEP_EXT; i++) begin
            lo_five[i] = tma_pkg::SAMPLE_TOP;
            hi_five[i] = tma_pkg::SAMPLE_BOT;
        end
    endtask

    // both lists stay ordered, most extreme first
    task automatic keep_extremes(input tma_pkg::t_sample s);
        int i;
        int j;
        for (i = 0; i < tma_pkg::KEEP_EXT; i++) begin
            if (s < lo_five[i]) begin
                for (j = tma_pkg::KEEP_EXT - 1; j > i; j--) lo_five[j] = lo_five[j-1];
                lo_five[i] = s;
                break;
            end
        end
        for (i = 0; i < tma_pkg::KEEP_EXT; i++) begin
            if (s > hi_five[i]) begin
                for (j = tma_pkg::KEEP_EXT - 1; j > i; j--) hi_five[j] = hi_five[j-1];
                hi_five[i] = s;
                break;
            end
        end
    endtask

    task automatic take_sample(input tma_pkg::t_in item);
        int            n;
        int            k;
        longint        rem;
        tma_pkg::t_out res;
        if (run_count < MAX_SAMPLES) begin
            run_sum   = run_sum + item.sample;
            run_count = run_count + 1'b1;
            keep_extremes(item.sample);
        end else begin
            run_ovf = 1'b1;
        end
        if (item.last) begin
            n = run_count;
            if (n > 19) begin
                k = 5;
            end else if (n > 10) begin
                k = 3;
            end else if (n > 6) begin
                k = 2;
            end else if (n > 2) begin
                k = 1;
            end else begin
                k = 0;
            end
            rem = run_sum;
            for (int i = 0; i < k; i++) begin
                rem -= longint'(lo_five[i]) + longint'(hi_five[i]);
            end
            res.mean     = (n > 0) ? tma_pkg::t_sample'(rem / (n - 2 * k)) : '0;
            res.overflow = run_ovf;
            mean_queue.push_back(res);
            clear_run();
        end
    endtask

    task automatic check_result(input tma_pkg::t_out got);
        tma_pkg::t_out want;
        if (mean_queue.size() == 0) begin
            report_mismatch("result with nothing pending, mean", got.mean, 0);
        end else begin
            want = mean_queue.pop_front();
            if (got.mean !== want.mean) report_mismatch("mean", got.mean, want.mean);
            if (got.overflow !== want.overflow) begin
                report_mismatch("overflow", got.overflow, want.overflow);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_run();
            mean_queue.delete();
        end else begin
            if (i_pop && !i_empty) check_result(i_out_data);
            if (i_push && !i_full) take_sample(i_in_data);
        end
        o_pending = mean_queue.size();
    end

endmodule

@@ bench/tb_trimmed_mean_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_mean_averager
// Drives runs of samples into the trimmed mean averager: a few hand-picked
// runs over the trim boundaries and sample extremes, then random runs of
// mixed length, some past the sample limit. Both sides stall at random
// outside one calm stretch. The checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_averager;

    localparam int RANDOM_ITEMS = 1100;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          pop     = 1'b0;
    logic          full;
    logic          empty;
    tma_pkg::t_in  i_data  = '0;
    tma_pkg::t_out o_data;
    logic          calm    = 1'b0;
    int            fail_count;
    int            pending;
    int            sent    = 0;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    trimmed_mean_averager i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    trimmed_mean_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_data    (i_data),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= 29);
    end

    task automatic send_sample(input tma_pkg::t_sample s, input logic last);
        bit done;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            if (!calm && $urandom_range(99) < 29) begin
                push <= 1'b0;
            end else begin
                push          <= 1'b1;
                i_data.sample <= s;
                i_data.last   <= last;
                @(posedge i_clk);
                done = !full;
            end
        end
        sent++;
        calm = (sent >= 500) && (sent < 700);
    endtask

    // narrow flavour crowds values together so the extremes lists see ties
    function automatic tma_pkg::t_sample pick_sample(input int flavour);
        int r;
        r = $urandom_range(99);
        if (r < 8) return tma_pkg::SAMPLE_TOP;
        if (r < 16) return tma_pkg::SAMPLE_BOT;
        if (flavour == 1) return tma_pkg::t_sample'(int'($urandom_range(8)) - 4);
        return tma_pkg::t_sample'($urandom);
    endfunction

    task automatic send_run(input int len);
        int flavour;
        flavour = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
            send_sample(pick_sample(flavour), i == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(tma_pkg::SAMPLE_TOP, 1'b1);
        send_sample(tma_pkg::SAMPLE_BOT, 1'b1);
        send_sample(tma_pkg::SAMPLE_TOP, 1'b0);
        send_sample(tma_pkg::SAMPLE_TOP, 1'b1);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(tma_pkg::SAMPLE_BOT, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(tma_pkg::SAMPLE_TOP, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(tma_pkg::SAMPLE_BOT, i == 5);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd3, 1'b1);

        // sample limit exactly reached, then just exceeded; trim boundaries
        send_run(tma_pkg::MAX_SAMPLES_DEF);
        send_run(tma_pkg::MAX_SAMPLES_DEF + 1);
        send_run(20);
        send_run(19);
        send_run(11);
        send_run(10);
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 4) begin
                len = $urandom_range(tma_pkg::MAX_SAMPLES_DEF + 7,
                                     tma_pkg::MAX_SAMPLES_DEF - 2);
            end else begin
                len = $urandom_range(24, 1);
            end
            send_run(len);
        end
        @(negedge i_clk);
        push <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("trimmed_mean_averager regression: pass");
        end else begin
            $display("trimmed_mean_averager regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("trimmed_mean_averager regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tma_pkg.sv
hw/rtl/tma_front.sv
hw/rtl/tma_queue.sv
hw/rtl/tma_back.sv
hw/rtl/trimmed_mean_averager.sv
bench/trimmed_mean_checker.sv
bench/tb_trimmed_mean_averager.sv
